>>> design/rhhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhhs_pkg
// Shared types and constants for the Robin Hood hash set.
// ----------------------------------------------------------------------------
package rhhs_pkg;

  // The slot count must be a power of two, because the home slot is taken
  // from the low key bits.
  localparam int TABLE_SLOTS = 64;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int KEY_W       = 32;
  localparam int OCC_W       = SLOT_W + 1;

  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 8;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_INSERT = 2'd0;
  localparam func_t FUNC_MEMBER = 2'd1;
  localparam func_t FUNC_REMOVE = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_FULL     = 2'd1;
  localparam status_t STATUS_ZERO_KEY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOC_RD,
    ST_LOC_CMP,
    ST_INS_RD,
    ST_INS_CMP,
    ST_RESP
  } state_t;

endpackage

>>> design/rhhs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhhs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rhhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/robin_hood_hash_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robin_hood_hash_set
// Robin Hood open-addressing set of nonzero 32-bit keys with insert, member
// and remove requests.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns one result transaction
// per request. Every slot probe first addresses the slot memory and then
// compares its registered read data, and a single compare and distance unit
// serves all probes. Member, remove and insert of a present key stop at the
// first match; an absent key or an insert into a full table scans the whole
// table. Insert of an absent key first scans the whole table and then probes
// from the home slot until an empty slot takes the carried key. A zero key or
// an unused operation code goes straight to the result. The slot memory reads
// as empty after reset with no clearing pass.
// ----------------------------------------------------------------------------
module robin_hood_hash_set (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rhhs_pkg::IN_DATA_W-1:0]  in_tdata,  // func[1:0], key[33:2]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rhhs_pkg::OUT_DATA_W-1:0] out_tdata  // found[0], status[2:1]
);

  import rhhs_pkg::*;

  state_t                 state_r, state_nxt;
  func_t                  func_r, func_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [SLOT_W-1:0]      j_r, j_nxt;
  logic [SLOT_W-1:0]      cnt_r, cnt_nxt;
  logic [OCC_W-1:0]       dist_r, dist_nxt;
  logic [OCC_W-1:0]       occ_r, occ_nxt;
  logic [TABLE_SLOTS-1:0] valid_r, valid_nxt;
  logic                   rd_valid_r;
  logic                   found_r, found_nxt;
  status_t                status_r, status_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]  out_tdata_r, out_tdata_nxt;

  logic                   ram_we;
  logic [KEY_W-1:0]       ram_wdata;
  logic [KEY_W-1:0]       ram_rdata;
  logic [KEY_W-1:0]       res_key;
  logic [SLOT_W-1:0]      res_dist;
  logic                   key_match;
  logic                   last_probe;
  logic                   table_full;
  logic                   accept;
  logic                   out_free;
  func_t                  in_func;
  logic [KEY_W-1:0]       in_key;

  assign in_func    = in_tdata[1:0];
  assign in_key     = in_tdata[KEY_W+1:2];
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign res_key    = rd_valid_r ? ram_rdata : '0;
  assign key_match  = (res_key == key_r);
  assign res_dist   = j_r - res_key[SLOT_W-1:0];
  assign last_probe = (cnt_r == SLOT_W'(TABLE_SLOTS - 1));
  assign table_full = (occ_r == OCC_W'(TABLE_SLOTS));

  rhhs_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(j_r),
    .wdata(ram_wdata),
    .raddr(j_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if ((in_func inside {FUNC_INSERT, FUNC_MEMBER, FUNC_REMOVE}) &&
              (in_key != '0)) begin
            state_nxt = ST_LOC_RD;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_LOC_RD: state_nxt = ST_LOC_CMP;
      ST_LOC_CMP: begin
        if (key_match) begin
          state_nxt = ST_RESP;
        end else if (last_probe) begin
          if (func_r == FUNC_INSERT && !table_full) begin
            state_nxt = ST_INS_RD;
          end else begin
            state_nxt = ST_RESP;
          end
        end else begin
          state_nxt = ST_LOC_RD;
        end
      end
      ST_INS_RD: state_nxt = ST_INS_CMP;
      ST_INS_CMP: begin
        if (res_key == '0) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_INS_RD;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    func_nxt       = func_r;
    key_nxt        = key_r;
    j_nxt          = j_r;
    cnt_nxt        = cnt_r;
    dist_nxt       = dist_r;
    occ_nxt        = occ_r;
    valid_nxt      = valid_r;
    found_nxt      = found_r;
    status_nxt     = status_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_wdata      = key_r;
    in_tready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          func_nxt   = in_func;
          key_nxt    = in_key;
          j_nxt      = in_key[SLOT_W-1:0];
          cnt_nxt    = '0;
          found_nxt  = 1'b0;
          status_nxt = (in_func == FUNC_INSERT && in_key == '0) ? STATUS_ZERO_KEY
                                                                 : STATUS_OK;
        end
      end
      ST_LOC_CMP: begin
        if (key_match) begin
          found_nxt = 1'b1;
          if (func_r == FUNC_REMOVE) begin
            valid_nxt[j_r] = 1'b0;
            occ_nxt        = occ_r - OCC_W'(1);
          end
        end else begin
          j_nxt   = j_r + SLOT_W'(1);
          cnt_nxt = cnt_r + SLOT_W'(1);
          if (last_probe && func_r == FUNC_INSERT) begin
            j_nxt    = key_r[SLOT_W-1:0];
            dist_nxt = '0;
            if (table_full) begin
              status_nxt = STATUS_FULL;
            end
          end
        end
      end
      ST_INS_CMP: begin
        if (res_key == '0) begin
          ram_we         = 1'b1;
          valid_nxt[j_r] = 1'b1;
          occ_nxt        = occ_r + OCC_W'(1);
        end else begin
          j_nxt = j_r + SLOT_W'(1);
          if ({1'b0, res_dist} < dist_r) begin
            ram_we   = 1'b1;
            key_nxt  = res_key;
            dist_nxt = {1'b0, res_dist} + OCC_W'(1);
          end else begin
            dist_nxt = dist_r + OCC_W'(1);
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{(OUT_DATA_W - 3){1'b0}}, status_r, found_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      occ_r        <= '0;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      valid_r      <= valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    key_r       <= key_nxt;
    j_r         <= j_nxt;
    cnt_r       <= cnt_nxt;
    dist_r      <= dist_nxt;
    found_r     <= found_nxt;
    status_r    <= status_nxt;
    out_tdata_r <= out_tdata_nxt;
    rd_valid_r  <= valid_r[j_r];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == OCC_W'($countones(valid_r)))
    else $error("Occupancy count disagrees with the slot valid bits.");

  a_write_only_in_insert: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_INS_CMP))
    else $error("Slot memory written outside insert placement.");

  a_zero_key_short: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_key == '0) |=> (state_r == ST_RESP))
    else $error("Zero key request did not go straight to the result.");

  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r == STATUS_FULL && state_r == ST_RESP) |-> !found_r)
    else $error("Full table result also reports a found key.");

endmodule

>>> dv/robin_hood_hash_set_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robin_hood_hash_set_tb
// Self-checking testbench for the Robin Hood hash set. A shadow copy of the
// slot table predicts the result of every accepted request, and each result
// transaction is compared with the oldest prediction. Directed requests cover
// zero keys, the unused operation, duplicates, wraparound and displacement.
// The table is then filled until it reports full and drained back to back.
// Random phases with clustered keys and varying operation mixes follow.
// ----------------------------------------------------------------------------
module robin_hood_hash_set_tb;
  import rhhs_pkg::*;

  localparam func_t FUNC_UNUSED  = 2'd3;
  localparam int    CYCLE_LIMIT  = 1_500_000;
  localparam int    SETTLE_TICKS = 300;

  typedef struct packed {
    logic    found;
    status_t status;
  } answer_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // func[1:0], key[33:2]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // found[0], status[2:1]

  logic [KEY_W-1:0] shadow_slots [TABLE_SLOTS];
  answer_t          pending_answers [$];
  int               mismatch_count = 0;
  bit               no_idle = 1'b0;
  int               cluster_home = 0;

  robin_hood_hash_set u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic int home_slot(logic [KEY_W-1:0] k);
    return int'(k % TABLE_SLOTS);
  endfunction

  function automatic int slot_holding(logic [KEY_W-1:0] k);
    int j;
    j = home_slot(k);
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (shadow_slots[j] == k) return j;
      j = (j + 1) % TABLE_SLOTS;
    end
    return TABLE_SLOTS;
  endfunction

  function automatic bit table_has_hole();
    for (int i = 0; i < TABLE_SLOTS; i++)
      if (shadow_slots[i] == '0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void place_key(logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] carried;
    logic [KEY_W-1:0] resident;
    int               j;
    int               carried_dist;
    int               rdist;
    carried = k;
    j = home_slot(k);
    carried_dist = 0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      resident = shadow_slots[j];
      if (resident == '0) begin
        shadow_slots[j] = carried;
        return;
      end
      rdist = (TABLE_SLOTS + j - home_slot(resident)) % TABLE_SLOTS;
      if (rdist < carried_dist) begin
        shadow_slots[j] = carried;
        carried = resident;
        carried_dist = rdist;
      end
      carried_dist++;
      j = (j + 1) % TABLE_SLOTS;
    end
  endfunction

  function automatic answer_t predict_answer(func_t f, logic [KEY_W-1:0] k);
    answer_t a;
    int      pos;
    a.found = 1'b0;
    a.status = STATUS_OK;
    pos = (k == '0) ? TABLE_SLOTS : slot_holding(k);
    case (f)
      FUNC_INSERT: begin
        if (k == '0) a.status = STATUS_ZERO_KEY;
        else if (pos < TABLE_SLOTS) a.found = 1'b1;
        else if (!table_has_hole()) a.status = STATUS_FULL;
        else place_key(k);
      end
      FUNC_MEMBER: a.found = (pos < TABLE_SLOTS);
      FUNC_REMOVE: begin
        if (pos < TABLE_SLOTS) begin
          shadow_slots[pos] = '0;
          a.found = 1'b1;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int               sel;
    int               j;
    logic [KEY_W-1:0] k;
    sel = $urandom_range(0, 99);
    k = $urandom();
    if (sel < 4) return '0;
    if (sel < 34) begin
      j = $urandom_range(0, TABLE_SLOTS - 1);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (shadow_slots[j] != '0) return shadow_slots[j];
        j = (j + 1) % TABLE_SLOTS;
      end
    end
    if (sel < 76) begin
      k[SLOT_W-1:0] = SLOT_W'((cluster_home + $urandom_range(0, 3)) % TABLE_SLOTS);
    end
    return k;
  endfunction

  task automatic send_request(func_t f, logic [KEY_W-1:0] k);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - KEY_W - 2){1'b0}}, k, f};
    do @(posedge clk); while (!in_tready);
    pending_answers.push_back(predict_answer(f, k));
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_for_answers();
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(FUNC_INSERT, 32'h0000_0000);
    send_request(FUNC_MEMBER, 32'h0000_0000);
    send_request(FUNC_REMOVE, 32'h0000_0000);
    send_request(FUNC_UNUSED, 32'h0000_0000);
    send_request(FUNC_UNUSED, 32'hFFFF_FFFF);
    send_request(FUNC_INSERT, 32'h0000_0041);
    send_request(FUNC_INSERT, 32'h0000_0040);
    send_request(FUNC_INSERT, 32'h0000_0080);
    send_request(FUNC_INSERT, 32'hFFFF_FFFF);
    send_request(FUNC_INSERT, 32'h0000_007F);
    send_request(FUNC_INSERT, 32'h0000_0080);
    send_request(FUNC_MEMBER, 32'h0000_0041);
    send_request(FUNC_MEMBER, 32'h0000_00C1);
    send_request(FUNC_REMOVE, 32'h0000_0040);
    send_request(FUNC_REMOVE, 32'h0000_0040);
    send_request(FUNC_MEMBER, 32'h0000_0080);
    send_request(FUNC_INSERT, 32'h0000_0080);
    send_request(FUNC_INSERT, 32'hAAAA_AAAA);
    send_request(FUNC_INSERT, 32'h5555_5555);
    send_request(FUNC_MEMBER, 32'hAAAA_AAAA);
    send_request(FUNC_MEMBER, 32'h5555_5555);
    send_request(FUNC_UNUSED, 32'h0000_0080);
    send_request(FUNC_MEMBER, 32'hFFFF_FFFF);
  endtask

  task automatic test_fill_to_full();
    logic [KEY_W-1:0] k;
    cluster_home = 60;
    while (table_has_hole()) begin
      do k = pick_key(); while (k == '0 || slot_holding(k) != TABLE_SLOTS);
      send_request(FUNC_INSERT, k);
    end
    do k = $urandom(); while (k == '0 || slot_holding(k) != TABLE_SLOTS);
    send_request(FUNC_INSERT, k);
    send_request(FUNC_INSERT, shadow_slots[5]);
    send_request(FUNC_MEMBER, shadow_slots[63]);
    send_request(FUNC_MEMBER, k);
    send_request(FUNC_REMOVE, shadow_slots[0]);
    send_request(FUNC_INSERT, k);
    send_request(FUNC_INSERT, ~k);
    wait_for_answers();
  endtask

  task automatic test_drain_back_to_back();
    logic [KEY_W-1:0] keys [$];
    int               idx;
    no_idle = 1'b1;
    for (int i = 0; i < TABLE_SLOTS; i++)
      if (shadow_slots[i] != '0) keys.push_back(shadow_slots[i]);
    while (keys.size() != 0) begin
      idx = $urandom_range(0, keys.size() - 1);
      send_request(FUNC_REMOVE, keys[idx]);
      keys.delete(idx);
    end
    send_request(FUNC_MEMBER, 32'h0000_0080);
    no_idle = 1'b0;
    wait_for_answers();
  endtask

  task automatic test_random_mix(int count, int insert_pct, int remove_pct);
    int    r;
    func_t f;
    cluster_home = $urandom_range(0, TABLE_SLOTS - 1);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) f = FUNC_INSERT;
      else if (r < insert_pct + remove_pct) f = FUNC_REMOVE;
      else if (r < 96) f = FUNC_MEMBER;
      else f = FUNC_UNUSED;
      if ($urandom_range(0, 19) == 0) cluster_home = $urandom_range(0, TABLE_SLOTS - 1);
      send_request(f, pick_key());
      if ($urandom_range(0, 49) == 0) wait_for_answers();
    end
    wait_for_answers();
  endtask

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) shadow_slots[i] = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_for_answers();
    test_fill_to_full();
    test_drain_back_to_back();
    test_random_mix(200, 60, 10);
    test_random_mix(200, 40, 35);
    test_random_mix(200, 75, 5);
    test_random_mix(200, 20, 55);
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_for_answers();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin : result_backpressure
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_results
    answer_t seen;
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.found  = out_tdata[0];
      seen.status = out_tdata[2:1];
      if (pending_answers.size() == 0) begin
        $error("Result transaction arrived with no request outstanding.");
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        if (seen.found !== want.found) begin
          $error("found mismatch: expected %0d, actual %0d", want.found, seen.found);
          mismatch_count++;
        end
        if (seen.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, seen.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
design/rhhs_pkg.sv
design/rhhs_ram.sv
design/robin_hood_hash_set.sv
dv/robin_hood_hash_set_tb.sv
